[rtl/cubic_hermite_segment_coefficients_unit_macros.svh]
// Assertion helpers for the cubic Hermite coefficient unit.
// Both expect clk and rst_n in scope.
`ifndef CUBIC_HERMITE_SEGMENT_COEFFICIENTS_UNIT_MACROS_SVH
`define CUBIC_HERMITE_SEGMENT_COEFFICIENTS_UNIT_MACROS_SVH

// same-cycle implication
`define CHSC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");

// next-cycle implication
`define CHSC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

[rtl/chsc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package chsc_pkg;

  localparam int BIG_W     = 192;  // working width, holds every numerator
  localparam int MUL_STEPS = 36;   // multiplier operand bits, signed
  localparam int DIV_STEPS = 66;   // quotient bits 65..0
  localparam int RF_DEPTH  = 20;
  localparam int RF_AW     = $clog2(RF_DEPTH);
  localparam int PC_W      = 7;
  localparam int K_W       = 7;
  localparam int CNT_W     = 7;
  localparam int Q_W       = 67;

  typedef struct packed {
    logic signed [31:0] node_x;
    logic signed [31:0] node_value;
    logic signed [31:0] node_slope;
    logic               first_node;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0] coef_cubic;
    logic signed [63:0] coef_square;
    logic signed [63:0] coef_linear;
    logic signed [63:0] coef_const;
    logic [1:0]         status;
  } out_item_t;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_FIRST   = 2'd1;
  localparam logic [1:0] STAT_SPACING = 2'd2;
  localparam logic [1:0] STAT_SAT     = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE, ST_FETCH, ST_LOAD, ST_RUN, ST_ROUND, ST_FINISH
  } state_t;

  typedef enum logic [2:0] {
    OP_LD, OP_ADD, OP_SUB, OP_SHL, OP_MUL, OP_DIV, OP_END
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [RF_AW-1:0] dst;
    logic [RF_AW-1:0] sa;
    logic [RF_AW-1:0] sb;
    logic [K_W-1:0]   k;
  } instr_t;

  // register file slots
  localparam logic [RF_AW-1:0] R_X1  = 5'd0;
  localparam logic [RF_AW-1:0] R_X2  = 5'd1;
  localparam logic [RF_AW-1:0] R_Y1  = 5'd2;
  localparam logic [RF_AW-1:0] R_Y2  = 5'd3;
  localparam logic [RF_AW-1:0] R_S1  = 5'd4;
  localparam logic [RF_AW-1:0] R_S2  = 5'd5;
  localparam logic [RF_AW-1:0] R_H   = 5'd6;
  localparam logic [RF_AW-1:0] R_DEN = 5'd7;
  localparam logic [RF_AW-1:0] R_X11 = 5'd8;
  localparam logic [RF_AW-1:0] R_X22 = 5'd9;
  localparam logic [RF_AW-1:0] R_X12 = 5'd10;
  localparam logic [RF_AW-1:0] R_NA  = 5'd11;
  localparam logic [RF_AW-1:0] R_NB  = 5'd12;
  localparam logic [RF_AW-1:0] R_NC  = 5'd13;
  localparam logic [RF_AW-1:0] R_ND  = 5'd14;
  localparam logic [RF_AW-1:0] R_T0  = 5'd15;
  localparam logic [RF_AW-1:0] R_T1  = 5'd16;
  localparam logic [RF_AW-1:0] R_T2  = 5'd17;
  localparam logic [RF_AW-1:0] R_T3  = 5'd18;
  localparam logic [RF_AW-1:0] R_T4  = 5'd19;

  // load sources
  localparam logic [K_W-1:0] SRC_X1 = 7'd0;
  localparam logic [K_W-1:0] SRC_X2 = 7'd1;
  localparam logic [K_W-1:0] SRC_Y1 = 7'd2;
  localparam logic [K_W-1:0] SRC_Y2 = 7'd3;
  localparam logic [K_W-1:0] SRC_S1 = 7'd4;
  localparam logic [K_W-1:0] SRC_S2 = 7'd5;

  // coefficient slots
  localparam logic [K_W-1:0] COEF_A = 7'd0;
  localparam logic [K_W-1:0] COEF_B = 7'd1;
  localparam logic [K_W-1:0] COEF_C = 7'd2;
  localparam logic [K_W-1:0] COEF_D = 7'd3;

  localparam logic [K_W-1:0] K_NONE = 7'd0;

  function automatic instr_t mk(input op_t op, input logic [RF_AW-1:0] dst,
                                input logic [RF_AW-1:0] sa, input logic [RF_AW-1:0] sb,
                                input logic [K_W-1:0] k);
    instr_t r;
    r.op  = op;
    r.dst = dst;
    r.sa  = sa;
    r.sb  = sb;
    r.k   = k;
    return r;
  endfunction

  // Program: numerators na..nd and h^3, then four divisions.
  // MUL: dst = sa * sb, sb must fit MUL_STEPS signed bits.
  function automatic instr_t prog_rom(input logic [PC_W-1:0] pc);
    instr_t r;
    case (pc)
      7'd0:  r = mk(OP_LD,  R_X1,  R_X1,  R_X1,  SRC_X1);
      7'd1:  r = mk(OP_LD,  R_X2,  R_X1,  R_X1,  SRC_X2);
      7'd2:  r = mk(OP_LD,  R_Y1,  R_X1,  R_X1,  SRC_Y1);
      7'd3:  r = mk(OP_LD,  R_Y2,  R_X1,  R_X1,  SRC_Y2);
      7'd4:  r = mk(OP_LD,  R_S1,  R_X1,  R_X1,  SRC_S1);
      7'd5:  r = mk(OP_LD,  R_S2,  R_X1,  R_X1,  SRC_S2);
      7'd6:  r = mk(OP_SUB, R_H,   R_X2,  R_X1,  K_NONE);
      7'd7:  r = mk(OP_MUL, R_T0,  R_H,   R_H,   K_NONE);
      7'd8:  r = mk(OP_MUL, R_DEN, R_T0,  R_H,   K_NONE);
      7'd9:  r = mk(OP_MUL, R_X11, R_X1,  R_X1,  K_NONE);
      7'd10: r = mk(OP_MUL, R_X22, R_X2,  R_X2,  K_NONE);
      7'd11: r = mk(OP_MUL, R_X12, R_X1,  R_X2,  K_NONE);
      // a
      7'd12: r = mk(OP_SUB, R_T0,  R_Y1,  R_Y2,  K_NONE);
      7'd13: r = mk(OP_SHL, R_T0,  R_T0,  R_T0,  7'd65);
      7'd14: r = mk(OP_ADD, R_T1,  R_S1,  R_S2,  K_NONE);
      7'd15: r = mk(OP_MUL, R_T1,  R_T1,  R_H,   K_NONE);
      7'd16: r = mk(OP_SHL, R_T1,  R_T1,  R_T1,  7'd48);
      7'd17: r = mk(OP_ADD, R_NA,  R_T0,  R_T1,  K_NONE);
      // b
      7'd18: r = mk(OP_ADD, R_T0,  R_X1,  R_X2,  K_NONE);
      7'd19: r = mk(OP_SHL, R_T1,  R_T0,  R_T0,  7'd1);
      7'd20: r = mk(OP_ADD, R_T0,  R_T0,  R_T1,  K_NONE);
      7'd21: r = mk(OP_SUB, R_T1,  R_Y2,  R_Y1,  K_NONE);
      7'd22: r = mk(OP_MUL, R_T0,  R_T0,  R_T1,  K_NONE);
      7'd23: r = mk(OP_SHL, R_T0,  R_T0,  R_T0,  7'd48);
      7'd24: r = mk(OP_SHL, R_T1,  R_X1,  R_X1,  7'd1);
      7'd25: r = mk(OP_ADD, R_T1,  R_T1,  R_X2,  K_NONE);
      7'd26: r = mk(OP_MUL, R_T1,  R_T1,  R_S2,  K_NONE);
      7'd27: r = mk(OP_SHL, R_T2,  R_X2,  R_X2,  7'd1);
      7'd28: r = mk(OP_ADD, R_T2,  R_T2,  R_X1,  K_NONE);
      7'd29: r = mk(OP_MUL, R_T2,  R_T2,  R_S1,  K_NONE);
      7'd30: r = mk(OP_ADD, R_T1,  R_T1,  R_T2,  K_NONE);
      7'd31: r = mk(OP_MUL, R_T1,  R_T1,  R_H,   K_NONE);
      7'd32: r = mk(OP_SHL, R_T1,  R_T1,  R_T1,  7'd32);
      7'd33: r = mk(OP_SUB, R_NB,  R_T0,  R_T1,  K_NONE);
      // c
      7'd34: r = mk(OP_SUB, R_T0,  R_Y1,  R_Y2,  K_NONE);
      7'd35: r = mk(OP_MUL, R_T0,  R_X12, R_T0,  K_NONE);
      7'd36: r = mk(OP_SHL, R_T1,  R_T0,  R_T0,  7'd1);
      7'd37: r = mk(OP_SHL, R_T0,  R_T0,  R_T0,  7'd2);
      7'd38: r = mk(OP_ADD, R_T0,  R_T0,  R_T1,  K_NONE);
      7'd39: r = mk(OP_SHL, R_T0,  R_T0,  R_T0,  7'd32);
      7'd40: r = mk(OP_SHL, R_T3,  R_X12, R_X12, 7'd1);
      7'd41: r = mk(OP_ADD, R_T1,  R_X11, R_T3,  K_NONE);
      7'd42: r = mk(OP_MUL, R_T1,  R_T1,  R_S2,  K_NONE);
      7'd43: r = mk(OP_ADD, R_T2,  R_X22, R_T3,  K_NONE);
      7'd44: r = mk(OP_MUL, R_T2,  R_T2,  R_S1,  K_NONE);
      7'd45: r = mk(OP_ADD, R_T1,  R_T1,  R_T2,  K_NONE);
      7'd46: r = mk(OP_MUL, R_T1,  R_T1,  R_H,   K_NONE);
      7'd47: r = mk(OP_SHL, R_T1,  R_T1,  R_T1,  7'd16);
      7'd48: r = mk(OP_ADD, R_NC,  R_T0,  R_T1,  K_NONE);
      // d
      7'd49: r = mk(OP_MUL, R_T0,  R_X11, R_X2,  K_NONE);
      7'd50: r = mk(OP_MUL, R_T1,  R_X22, R_X1,  K_NONE);
      7'd51: r = mk(OP_MUL, R_T2,  R_X11, R_X1,  K_NONE);
      7'd52: r = mk(OP_SHL, R_T3,  R_T0,  R_T0,  7'd1);
      7'd53: r = mk(OP_ADD, R_T3,  R_T3,  R_T0,  K_NONE);
      7'd54: r = mk(OP_SUB, R_T3,  R_T3,  R_T2,  K_NONE);
      7'd55: r = mk(OP_MUL, R_T3,  R_T3,  R_Y2,  K_NONE);
      7'd56: r = mk(OP_MUL, R_T2,  R_X22, R_X2,  K_NONE);
      7'd57: r = mk(OP_SHL, R_T4,  R_T1,  R_T1,  7'd1);
      7'd58: r = mk(OP_ADD, R_T4,  R_T4,  R_T1,  K_NONE);
      7'd59: r = mk(OP_SUB, R_T4,  R_T4,  R_T2,  K_NONE);
      7'd60: r = mk(OP_MUL, R_T4,  R_T4,  R_Y1,  K_NONE);
      7'd61: r = mk(OP_SUB, R_T3,  R_T3,  R_T4,  K_NONE);
      7'd62: r = mk(OP_SHL, R_T3,  R_T3,  R_T3,  7'd16);
      7'd63: r = mk(OP_MUL, R_T0,  R_T0,  R_S2,  K_NONE);
      7'd64: r = mk(OP_MUL, R_T1,  R_T1,  R_S1,  K_NONE);
      7'd65: r = mk(OP_ADD, R_T0,  R_T0,  R_T1,  K_NONE);
      7'd66: r = mk(OP_MUL, R_T0,  R_T0,  R_H,   K_NONE);
      7'd67: r = mk(OP_SUB, R_ND,  R_T3,  R_T0,  K_NONE);
      // quotients
      7'd68: r = mk(OP_DIV, R_NA,  R_NA,  R_DEN, COEF_A);
      7'd69: r = mk(OP_DIV, R_NB,  R_NB,  R_DEN, COEF_B);
      7'd70: r = mk(OP_DIV, R_NC,  R_NC,  R_DEN, COEF_C);
      7'd71: r = mk(OP_DIV, R_ND,  R_ND,  R_DEN, COEF_D);
      default: r = mk(OP_END, R_X1, R_X1, R_X1, K_NONE);
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

[rtl/chsc_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
module chsc_ram #(
  parameter int WIDTH = chsc_pkg::BIG_W,
  parameter int DEPTH = chsc_pkg::RF_DEPTH
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule
`default_nettype wire

[rtl/cubic_hermite_segment_coefficients_unit.sv]
// Early out (first node or non-positive spacing): the request goes from idle straight to
// the finish state and is posted from there. A full request runs 45 load, add and shift
// steps, 23 multiplies and 4 divisions, all arithmetic on the one shared 192-bit adder.
// A request is taken only in idle, so none is accepted before the last is done; the
// output register holds the previous result meanwhile.
// Reset (rst_n low, synchronous): idle, no result pending, previous node cleared.
`timescale 1ns / 1ps
`default_nettype none
`include "cubic_hermite_segment_coefficients_unit_macros.svh"
module cubic_hermite_segment_coefficients_unit (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire chsc_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output chsc_pkg::out_item_t      out_data
);

  localparam int BW = chsc_pkg::BIG_W;

  chsc_pkg::state_t state_r, state_nxt;
  chsc_pkg::instr_t ins;

  logic [chsc_pkg::PC_W-1:0]  pc_r, pc_nxt;
  logic [chsc_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [BW-1:0]              acc_r, acc_nxt;   // product sum, or remainder
  logic [BW-1:0]              opa_r, opa_nxt;   // multiplicand, or shifted divisor
  logic [chsc_pkg::MUL_STEPS-1:0] opb_r, opb_nxt;
  logic [BW-1:0]              den_r, den_nxt;
  logic [chsc_pkg::Q_W-1:0]   q_r, q_nxt;
  logic                       neg_r, neg_nxt;
  logic                       sat_r, sat_nxt;
  logic [1:0]                 st_r, st_nxt;
  logic [63:0]                coef_r [4];
  logic [63:0]                coef_nxt [4];

  // previous node (stored) and the left end of the running interval
  logic [31:0] prev_x_r, prev_x_nxt, prev_y_r, prev_y_nxt, prev_s_r, prev_s_nxt;
  logic [31:0] x1_r, x1_nxt, y1_r, y1_nxt, s1_r, s1_nxt;
  logic        have_prev_r, have_prev_nxt;

  logic                out_valid_r, out_valid_nxt;
  chsc_pkg::out_item_t out_data_r, out_data_nxt;

  // register file
  logic          rf_we;
  logic [BW-1:0] rf_wdata, rf_rdata_a, rf_rdata_b;

  // shared adder
  logic [BW-1:0] add_a, add_b, add_res;
  logic          add_sub, add_carry;
  logic [BW:0]   add_sum;

  logic [BW-1:0]              ld_val, acc_step;
  logic [31:0]                ld_raw;
  logic [32:0]                h_diff;
  logic                       h_nonpos, first_in;
  logic [chsc_pkg::Q_W-1:0]   q_rnd;
  logic [63:0]                q_mag, q_val;
  logic                       q_sat;

  assign ins = chsc_pkg::prog_rom(pc_r);

  chsc_ram #(
    .WIDTH(chsc_pkg::BIG_W),
    .DEPTH(chsc_pkg::RF_DEPTH)
  ) u_rf (
    .clk    (clk),
    .we     (rf_we),
    .waddr  (ins.dst),
    .wdata  (rf_wdata),
    .raddr_a(ins.sa),
    .raddr_b(ins.sb),
    .rdata_a(rf_rdata_a),
    .rdata_b(rf_rdata_b)
  );

  assign add_sum   = {1'b0, add_a} + {1'b0, (add_sub ? ~add_b : add_b)}
                   + {{BW{1'b0}}, add_sub};
  assign add_res   = add_sum[BW-1:0];
  assign add_carry = add_sum[BW];     // on subtract: a >= b unsigned

  // spacing test on the incoming request
  assign h_diff   = {in_data.node_x[31], in_data.node_x} - {prev_x_r[31], prev_x_r};
  assign h_nonpos = h_diff[32] || (h_diff == 33'd0);
  assign first_in = in_data.first_node || !have_prev_r;

  always_comb begin
    case (ins.k)
      chsc_pkg::SRC_X1: ld_raw = x1_r;
      chsc_pkg::SRC_X2: ld_raw = prev_x_r;
      chsc_pkg::SRC_Y1: ld_raw = y1_r;
      chsc_pkg::SRC_Y2: ld_raw = prev_y_r;
      chsc_pkg::SRC_S1: ld_raw = s1_r;
      chsc_pkg::SRC_S2: ld_raw = prev_s_r;
      default:          ld_raw = 32'd0;
    endcase
  end
  assign ld_val = {{(BW-32){ld_raw[31]}}, ld_raw};

  // rounding and saturation of the finished quotient
  always_comb begin
    q_rnd = q_r + {{(chsc_pkg::Q_W-1){1'b0}}, add_carry};
    q_mag = q_rnd[63:0];
    q_sat = (|q_rnd[chsc_pkg::Q_W-1:64])
          || (!neg_r && q_mag[63])
          || (neg_r && q_mag[63] && (|q_mag[62:0]));
    if (q_sat) begin
      q_val = neg_r ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    end else begin
      q_val = neg_r ? (64'd0 - q_mag) : q_mag;
    end
  end

  assign in_ready = (state_r == chsc_pkg::ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    pc_nxt        = pc_r;
    cnt_nxt       = cnt_r;
    acc_nxt       = acc_r;
    opa_nxt       = opa_r;
    opb_nxt       = opb_r;
    den_nxt       = den_r;
    q_nxt         = q_r;
    neg_nxt       = neg_r;
    sat_nxt       = sat_r;
    st_nxt        = st_r;
    coef_nxt      = coef_r;
    prev_x_nxt    = prev_x_r;
    prev_y_nxt    = prev_y_r;
    prev_s_nxt    = prev_s_r;
    x1_nxt        = x1_r;
    y1_nxt        = y1_r;
    s1_nxt        = s1_r;
    have_prev_nxt = have_prev_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    rf_we         = 1'b0;
    rf_wdata      = add_res;
    add_a         = rf_rdata_a;
    add_b         = rf_rdata_b;
    add_sub       = 1'b0;
    acc_step      = acc_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      chsc_pkg::ST_IDLE: begin
        if (in_valid) begin
          x1_nxt        = prev_x_r;
          y1_nxt        = prev_y_r;
          s1_nxt        = prev_s_r;
          prev_x_nxt    = in_data.node_x;
          prev_y_nxt    = in_data.node_value;
          prev_s_nxt    = in_data.node_slope;
          have_prev_nxt = 1'b1;
          sat_nxt       = 1'b0;
          pc_nxt        = '0;
          for (int i = 0; i < 4; i++) coef_nxt[i] = 64'd0;
          if (first_in) begin
            st_nxt    = chsc_pkg::STAT_FIRST;
            state_nxt = chsc_pkg::ST_FINISH;
          end else if (h_nonpos) begin
            st_nxt    = chsc_pkg::STAT_SPACING;
            state_nxt = chsc_pkg::ST_FINISH;
          end else begin
            st_nxt    = chsc_pkg::STAT_OK;
            state_nxt = chsc_pkg::ST_FETCH;
          end
        end
      end
      chsc_pkg::ST_FETCH: begin
        state_nxt = chsc_pkg::ST_LOAD;   // register file read in flight
      end
      chsc_pkg::ST_LOAD: begin
        case (ins.op)
          chsc_pkg::OP_LD: begin
            rf_we     = 1'b1;
            rf_wdata  = ld_val;
            pc_nxt    = pc_r + 1'b1;
            state_nxt = chsc_pkg::ST_FETCH;
          end
          chsc_pkg::OP_ADD, chsc_pkg::OP_SUB: begin
            add_sub   = (ins.op == chsc_pkg::OP_SUB);
            rf_we     = 1'b1;
            pc_nxt    = pc_r + 1'b1;
            state_nxt = chsc_pkg::ST_FETCH;
          end
          chsc_pkg::OP_SHL: begin
            rf_we     = 1'b1;
            rf_wdata  = rf_rdata_a << ins.k;
            pc_nxt    = pc_r + 1'b1;
            state_nxt = chsc_pkg::ST_FETCH;
          end
          chsc_pkg::OP_MUL: begin
            opa_nxt   = rf_rdata_a;
            opb_nxt   = rf_rdata_b[chsc_pkg::MUL_STEPS-1:0];
            acc_nxt   = '0;
            cnt_nxt   = '0;
            state_nxt = chsc_pkg::ST_RUN;
          end
          chsc_pkg::OP_DIV: begin
            // magnitude of the numerator through the adder
            add_a     = '0;
            add_b     = rf_rdata_a;
            add_sub   = rf_rdata_a[BW-1];
            acc_nxt   = add_res;
            neg_nxt   = rf_rdata_a[BW-1];
            opa_nxt   = rf_rdata_b << (chsc_pkg::DIV_STEPS - 1);
            den_nxt   = rf_rdata_b;
            q_nxt     = '0;
            cnt_nxt   = '0;
            state_nxt = chsc_pkg::ST_RUN;
          end
          default: begin
            state_nxt = chsc_pkg::ST_FINISH;
          end
        endcase
      end
      chsc_pkg::ST_RUN: begin
        if (ins.op == chsc_pkg::OP_MUL) begin
          // shift-add; the top multiplier bit carries negative weight
          add_a    = acc_r;
          add_b    = opa_r;
          add_sub  = (cnt_r == chsc_pkg::CNT_W'(chsc_pkg::MUL_STEPS - 1));
          acc_step = opb_r[0] ? add_res : acc_r;
          acc_nxt  = acc_step;
          opa_nxt  = {opa_r[BW-2:0], 1'b0};
          opb_nxt  = {1'b0, opb_r[chsc_pkg::MUL_STEPS-1:1]};
          cnt_nxt  = cnt_r + 1'b1;
          if (cnt_r == chsc_pkg::CNT_W'(chsc_pkg::MUL_STEPS - 1)) begin
            rf_we     = 1'b1;
            rf_wdata  = acc_step;
            pc_nxt    = pc_r + 1'b1;
            state_nxt = chsc_pkg::ST_FETCH;
          end
        end else begin
          // restoring division, one quotient bit per cycle
          add_a   = acc_r;
          add_b   = opa_r;
          add_sub = 1'b1;
          if (add_carry) begin
            acc_nxt = add_res;
          end
          q_nxt   = {q_r[chsc_pkg::Q_W-2:0], add_carry};
          opa_nxt = {1'b0, opa_r[BW-1:1]};
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_r == chsc_pkg::CNT_W'(chsc_pkg::DIV_STEPS - 1)) begin
            state_nxt = chsc_pkg::ST_ROUND;
          end
        end
      end
      chsc_pkg::ST_ROUND: begin
        // round half away from zero: 2*rem >= den
        add_a    = {acc_r[BW-2:0], 1'b0};
        add_b    = den_r;
        add_sub  = 1'b1;
        coef_nxt[ins.k[1:0]] = q_val;
        sat_nxt  = sat_r || q_sat;
        pc_nxt   = pc_r + 1'b1;
        state_nxt = chsc_pkg::ST_FETCH;
      end
      chsc_pkg::ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          out_data_nxt.coef_cubic  = coef_r[chsc_pkg::COEF_A[1:0]];
          out_data_nxt.coef_square = coef_r[chsc_pkg::COEF_B[1:0]];
          out_data_nxt.coef_linear = coef_r[chsc_pkg::COEF_C[1:0]];
          out_data_nxt.coef_const  = coef_r[chsc_pkg::COEF_D[1:0]];
          out_data_nxt.status      = sat_r ? chsc_pkg::STAT_SAT : st_r;
          out_valid_nxt = 1'b1;
          state_nxt     = chsc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = chsc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= chsc_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      have_prev_r <= 1'b0;
      prev_x_r    <= 32'd0;
      prev_y_r    <= 32'd0;
      prev_s_r    <= 32'd0;
      sat_r       <= 1'b0;
      st_r        <= chsc_pkg::STAT_OK;
      pc_r        <= '0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      have_prev_r <= have_prev_nxt;
      prev_x_r    <= prev_x_nxt;
      prev_y_r    <= prev_y_nxt;
      prev_s_r    <= prev_s_nxt;
      sat_r       <= sat_nxt;
      st_r        <= st_nxt;
      pc_r        <= pc_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  // datapath, no reset
  always_ff @(posedge clk) begin
    acc_r      <= acc_nxt;
    opa_r      <= opa_nxt;
    opb_r      <= opb_nxt;
    den_r      <= den_nxt;
    q_r        <= q_nxt;
    neg_r      <= neg_nxt;
    x1_r       <= x1_nxt;
    y1_r       <= y1_nxt;
    s1_r       <= s1_nxt;
    out_data_r <= out_data_nxt;
    for (int i = 0; i < 4; i++) coef_r[i] <= coef_nxt[i];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a finished result is posted once the output slot frees up
  `CHSC_ASSERT_NXT(a_finish_posts, (state_r == chsc_pkg::ST_FINISH) && (!out_valid_r || out_ready), out_valid_r && (state_r == chsc_pkg::ST_IDLE))
  // early-out results carry all-zero coefficients
  `CHSC_ASSERT_IMP(a_early_zero, out_valid_r && (out_data_r.status == chsc_pkg::STAT_FIRST || out_data_r.status == chsc_pkg::STAT_SPACING), (out_data_r.coef_cubic == 64'd0) && (out_data_r.coef_square == 64'd0) && (out_data_r.coef_linear == 64'd0) && (out_data_r.coef_const == 64'd0))
  // iteration counter stays within the longest loop
  `CHSC_ASSERT_IMP(a_run_cnt, state_r == chsc_pkg::ST_RUN, cnt_r < chsc_pkg::CNT_W'(chsc_pkg::DIV_STEPS))

endmodule
`default_nettype wire
